[design/bts_pkg.sv]
// Shared types, constants and the simple-point lookup for the thinning subpass.
package bts_pkg;

  // Configuration port
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 11;

  localparam logic [CFG_IW-1:0] REG_DIRECTION    = 2'd0;
  localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = 2'd2;

  // Deletion side codes
  localparam logic [1:0] DIR_NORTH = 2'd0;
  localparam logic [1:0] DIR_SOUTH = 2'd1;
  localparam logic [1:0] DIR_WEST  = 2'd2;
  localparam logic [1:0] DIR_EAST  = 2'd3;

  // Map layout, bit 8 down to bit 0:  a b c / d e f / g h i
  localparam logic [8:0] SIDE_NORTH  = 9'o200;
  localparam logic [8:0] SIDE_SOUTH  = 9'o002;
  localparam logic [8:0] SIDE_WEST   = 9'o040;
  localparam logic [8:0] SIDE_EAST   = 9'o010;
  localparam logic [8:0] SHIFT_KEEP  = 9'o666;
  localparam logic [8:0] RIGHT_EDGE  = 9'o111;
  localparam logic [8:0] LEFT_EDGE   = 9'o444;

  // One column of the window as it enters, with the edge flags of its centre.
  typedef struct packed {
    logic top;
    logic mid;
    logic bot;
    logic ci0;
    logic ci1;
  } col_t;

  // Simple-point table. Every deletable map has its centre set, so the
  // table is a 16-bit row pattern chosen by bits 8:5, indexed by bits 3:0.
  function automatic logic simple_ok(input logic [8:0] map);
    logic [15:0] pat;
    pat = 16'h0000;
    case (map[8:5])
      4'd0:                      pat = 16'hCEC8;
      4'd1:                      pat = 16'hCCDC;
      4'd2, 4'd4:                pat = 16'hCF00;
      4'd3, 4'd11:               pat = 16'hCC00;
      4'd5, 4'd7, 4'd13, 4'd15:  pat = 16'hFFDD;
      4'd6, 4'd12, 4'd14:        pat = 16'hCF01;
      4'd9:                      pat = 16'hCCDD;
      default:                   pat = 16'h0000;
    endcase
    return map[4] & pat[map[3:0]];
  endfunction

  function automatic logic [8:0] side_mask(input logic [1:0] dir);
    logic [8:0] m;
    m = SIDE_NORTH;
    unique case (dir)
      DIR_NORTH: m = SIDE_NORTH;
      DIR_SOUTH: m = SIDE_SOUTH;
      DIR_WEST:  m = SIDE_WEST;
      DIR_EAST:  m = SIDE_EAST;
      default:   m = SIDE_NORTH;
    endcase
    return m;
  endfunction

endpackage

[design/binary_thinning_subpass.sv]
// A result leaves the output register after its beat has passed the first stage; a stalled output holds both.
// Throughput: one pixel beat per cycle unless the output stalls; the line store takes one read and one write a cycle.
// A result belongs to the beat frame_width+1 beats earlier; the first such beats give none.
// Reset clears position, configuration (direction 0, size 1024 or the maximum) and valids.
// The line store is not cleared; rows above the frame are masked by the row position.
module binary_thinning_subpass #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bts_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [bts_pkg::CFG_DW-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        pixel_in,
  input  logic                        pad,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        pixel_out,
  output logic                        deleted,
  output logic                        last_of_frame
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int WIDTH_RST  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int HEIGHT_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

  function automatic logic [WW-1:0] clamp_w(input logic [bts_pkg::CFG_DW-1:0] v);
    logic [31:0] vx;
    vx = 32'(v);
    if (vx < 32'd2) begin
      return WW'(2);
    end else if (vx > 32'(MAX_WIDTH)) begin
      return WW'(MAX_WIDTH);
    end
    return WW'(vx);
  endfunction

  function automatic logic [RW-1:0] clamp_h(input logic [bts_pkg::CFG_DW-1:0] v);
    logic [31:0] vx;
    vx = 32'(v);
    if (vx < 32'd2) begin
      return RW'(2);
    end else if (vx > 32'(MAX_HEIGHT)) begin
      return RW'(MAX_HEIGHT);
    end
    return RW'(vx);
  endfunction

  // Configuration and position
  logic [1:0]    direction;
  logic [WW-1:0] width_q;
  logic [RW-1:0] height_q;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [CW-1:0] col_eff;
  logic [RW-1:0] row_eff;
  logic [RW-1:0] h_p1;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;
  logic          frame_end;
  logic          row_wrap;
  logic          in_fire;
  logic          cfg_fire;
  logic          cfg_size;

  // First stage: beat waiting for its line store read
  logic          s1_valid;
  logic [CW-1:0] s1_ci;
  logic          s1_bot;
  logic          s1_top_en;
  logic          s1_mid_en;
  logic          s1_emit;
  logic          s1_ci0;
  logic          s1_ci1;
  logic          s1_last;
  logic          s1_go;
  logic [1:0]    rd_data;
  bts_pkg::col_t kcol;
  logic          k_keep;
  logic          k_del;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign cfg_size  = cfg_fire && (cfg_index == bts_pkg::REG_FRAME_WIDTH ||
                                  cfg_index == bts_pkg::REG_FRAME_HEIGHT);

  assign s1_go    = s1_valid & (~out_valid | out_ready);
  assign in_ready = ~s1_valid | s1_go;
  assign in_fire  = in_valid & in_ready;

  always_comb begin
    h_p1      = height_q + RW'(1);
    col_eff   = (WW'(col) >= width_q) ? '0 : col;
    row_eff   = (row > h_p1) ? '0 : row;
    frame_end = (row_eff == h_p1) && (col_eff == '0);
    row_wrap  = (WW'(col_eff) + WW'(1)) >= width_q;
    if (frame_end) begin
      col_next = '0;
      row_next = '0;
    end else if (row_wrap) begin
      col_next = '0;
      row_next = row_eff + RW'(1);
    end else begin
      col_next = col_eff + CW'(1);
      row_next = row_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= bts_pkg::DIR_NORTH;
      width_q   <= WW'(WIDTH_RST);
      height_q  <= RW'(HEIGHT_RST);
      col       <= '0;
      row       <= '0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index)
          bts_pkg::REG_DIRECTION:    direction <= cfg_data[1:0];
          bts_pkg::REG_FRAME_WIDTH:  width_q   <= clamp_w(cfg_data);
          bts_pkg::REG_FRAME_HEIGHT: height_q  <= clamp_h(cfg_data);
          default: ;
        endcase
      end
      if (cfg_size) begin
        col <= '0;
        row <= '0;
      end else if (in_fire) begin
        col <= col_next;
        row <= row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ci     <= col_eff;
      s1_bot    <= pixel_in & ~pad & (row_eff < height_q);
      s1_top_en <= row_eff >= RW'(2);
      s1_mid_en <= row_eff >= RW'(1);
      s1_emit   <= (row_eff >= RW'(2)) || ((row_eff == RW'(1)) && (col_eff != '0));
      s1_ci0    <= col_eff == '0;
      s1_ci1    <= col_eff == CW'(1);
      s1_last   <= frame_end;
    end
  end

  // The write of a column lands when its beat leaves the first stage; the
  // next beat reads a different column since a row is at least two wide.
  // Only after the frame's last beat does column 0 repeat, and row 0 masks that read.
  bts_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_lines (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (col_eff),
    .rd_data (rd_data),
    .wr_en   (s1_go),
    .wr_addr (s1_ci),
    .wr_data ({kcol.mid, s1_bot})
  );

  assign kcol.top = rd_data[1] & s1_top_en;
  assign kcol.mid = rd_data[0] & s1_mid_en;
  assign kcol.bot = s1_bot;
  assign kcol.ci0 = s1_ci0;
  assign kcol.ci1 = s1_ci1;

  bts_kernel u_kernel (
    .clk       (clk),
    .rst       (rst),
    .shift_en  (s1_go),
    .col       (kcol),
    .direction (direction),
    .keep      (k_keep),
    .del       (k_del)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= s1_emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      pixel_out     <= k_keep;
      deleted       <= k_del;
      last_of_frame <= s1_last;
    end
  end

endmodule

[design/bts_line_store.sv]
// Two-row line store: each entry holds the upper and middle row pixel of one column.
module bts_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [1:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [1:0]    wr_data
);

  logic [1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/bts_kernel.sv]
// 3x3 window register and the deletion decision for its centre pixel.
module bts_kernel (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift_en,
  input  bts_pkg::col_t   col,
  input  logic [1:0]      direction,
  output logic            keep,
  output logic            del
);

  logic [8:0] window_bits;
  logic [8:0] window_next;
  logic [8:0] map;
  logic       center;

  assign window_next = ((window_bits << 1) & bts_pkg::SHIFT_KEEP)
                     | {2'b00, col.top, 6'b000000}
                     | {5'b00000, col.mid, 3'b000}
                     | {8'b00000000, col.bot};

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bits <= '0;
    end else if (shift_en) begin
      window_bits <= window_next;
    end
  end

  // The newest column belongs to the next row when the centre sits on the
  // right edge, and the oldest one to the previous row on the left edge.
  always_comb begin
    map = window_next;
    if (col.ci0) begin
      map = map & ~bts_pkg::RIGHT_EDGE;
    end
    if (col.ci1) begin
      map = map & ~bts_pkg::LEFT_EDGE;
    end
  end

  assign center = map[4];
  assign del    = center && ((map & bts_pkg::side_mask(direction)) == 9'd0)
                  && bts_pkg::simple_ok(map);
  assign keep   = center & ~del;

endmodule

[design/bts_checker.sv]
// Port-level checks for the thinning subpass, bound to the top level.
module bts_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic pixel_out,
  input logic deleted,
  input logic last_of_frame
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({pixel_out, deleted, last_of_frame}))
    else $error("result beat changed while stalled");

  // A deleted pixel is always reported as cleared.
  a_del_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && deleted |-> !pixel_out)
    else $error("deleted pixel reported as set");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // With the output being drained the input never stalls.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output is drained");

endmodule

bind binary_thinning_subpass bts_checker u_bts_checker (.*);
